// ===== design/rbfs_pkg.sv =====
// ----------------------------------------------------------------------------
// rbfs_pkg
// Shared types and codes for the region best-fit select unit: controller
// states, operation codes, select modes, result source codes and register indexes.
// ----------------------------------------------------------------------------
package rbfs_pkg;

  // fixed field widths
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;
  localparam int SOURCE_W = 2;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 7;

  // operation codes of an input word
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // select modes
  localparam logic MODE_BEST_FIT = 1'b0;
  localparam logic MODE_FIRST_HIT = 1'b1;

  // result source codes
  localparam logic [SOURCE_W-1:0] SRC_MATCH = 2'd0;
  localparam logic [SOURCE_W-1:0] SRC_DEFAULT = 2'd1;
  localparam logic [SOURCE_W-1:0] SRC_BOSS = 2'd2;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SECTION_COUNT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SELECT_MODE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BOSS_LOCK_ENABLE = 2'd2;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

// ===== design/region_best_fit_select_unit.sv =====
// ----------------------------------------------------------------------------
// region_best_fit_select_unit
// Section rectangle table in one synchronous memory, searched by a query
// rectangle in best-fit or first-overlap mode through a four-stage pipeline.
// ----------------------------------------------------------------------------
// A write word (opcode 0) stores one section rectangle; it gives no result.
// A query word (opcode 1) gives exactly one result word, shown for one cycle
// with done high. A boss-lock query answers in the next cycle. Any other
// query reads the section memory one entry per cycle, section_count entries
// capped at MAX_SECTIONS, and feeds each entry through an overlap, a
// multiply, a distance-sum and a ranking stage. busy is high while a query
// scans; the next word is taken in the cycle the result shows.
// The receiver cannot stall: a result must be taken when done is high.
// Sections that a query searches must have been written before.
module region_best_fit_select_unit #(
  parameter int MAX_SECTIONS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration port
  input  logic                                  cfg_we,
  input  logic [rbfs_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [rbfs_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  // input word
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  opcode,
  input  logic [rbfs_pkg::INDEX_W-1:0]          entry_index,
  input  logic signed [COORD_BITS-1:0]          rect_x,
  input  logic signed [COORD_BITS-1:0]          rect_y,
  input  logic [COORD_BITS-2:0]                 rect_w,
  input  logic [COORD_BITS-2:0]                 rect_h,
  input  logic                                  boss_locked,
  // result word
  output logic                                  done,
  output logic [rbfs_pkg::SOURCE_W-1:0]         source,
  output logic [rbfs_pkg::INDEX_W-1:0]          section_index
);

  localparam int C = COORD_BITS;
  localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CW = $clog2(MAX_SECTIONS + 1);
  localparam int EW = 4 * C - 2;
  localparam int OVW = 2 * C - 2;
  localparam int DXW = C + 2;
  localparam int DW = 2 * C + 5;

  // configuration registers
  logic [rbfs_pkg::COUNT_W-1:0] section_count;
  logic                         select_mode;
  logic                         boss_lock_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      section_count <= '0;
      select_mode <= 1'b0;
      boss_lock_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        rbfs_pkg::REG_SECTION_COUNT:    section_count <= cfg_wdata;
        rbfs_pkg::REG_SELECT_MODE:      select_mode <= cfg_wdata[0];
        rbfs_pkg::REG_BOSS_LOCK_ENABLE: boss_lock_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // controller
  rbfs_pkg::state_t state, state_next;
  logic accept, accept_query, accept_write, boss_hit;
  logic issue, finish;
  logic [CW-1:0] rd_cnt, scan_n, scan_n_next;
  logic rd_valid, b_valid, c_valid, d_valid;

  assign accept = start && !busy;
  assign accept_query = accept && (opcode == rbfs_pkg::OP_QUERY);
  assign accept_write = accept && (opcode == rbfs_pkg::OP_WRITE);
  assign boss_hit = boss_locked && boss_lock_enable;

  // search length capped at the table depth
  always_comb begin
    if (32'(section_count) > MAX_SECTIONS) scan_n_next = CW'(MAX_SECTIONS);
    else scan_n_next = CW'(section_count);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rbfs_pkg::ST_IDLE: begin
        if (accept_query && !boss_hit) state_next = rbfs_pkg::ST_SCAN;
      end
      rbfs_pkg::ST_SCAN: begin
        if (finish) state_next = rbfs_pkg::ST_IDLE;
      end
      default: state_next = rbfs_pkg::ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    busy = 1'b0;
    issue = 1'b0;
    finish = 1'b0;
    case (state)
      rbfs_pkg::ST_IDLE: ;
      rbfs_pkg::ST_SCAN: begin
        busy = 1'b1;
        issue = rd_cnt < scan_n;
        finish = !issue && !rd_valid && !b_valid && !c_valid && !d_valid;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= rbfs_pkg::ST_IDLE;
    else state <= state_next;
  end

  // read counter
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt <= '0;
      scan_n <= '0;
    end else if (accept_query) begin
      rd_cnt <= '0;
      scan_n <= scan_n_next;
    end else if (issue) begin
      rd_cnt <= rd_cnt + CW'(1);
    end
  end

  // section memory
  logic [EW-1:0] mem [MAX_SECTIONS];
  logic [EW-1:0] rd_data;
  logic [AW-1:0] rd_tag;
  logic [31:0]   wr_ext;
  logic          wr_ok;

  assign wr_ext = 32'(entry_index);
  assign wr_ok = accept_write && (wr_ext < MAX_SECTIONS);

  always_ff @(posedge clk) begin
    if (wr_ok) mem[wr_ext[AW-1:0]] <= {rect_x, rect_y, rect_w, rect_h};
    rd_data <= mem[rd_cnt[AW-1:0]];
    rd_tag <= rd_cnt[AW-1:0];
  end

  // query rectangle, edges and doubled center
  logic signed [C:0]   q_x, q_y, q_right, q_bottom;
  logic signed [C+1:0] q_cx2, q_cy2;

  always_ff @(posedge clk) begin
    if (accept_query) begin
      q_x <= {rect_x[C-1], rect_x};
      q_y <= {rect_y[C-1], rect_y};
      q_right <= $signed({rect_x[C-1], rect_x}) + $signed({2'b00, rect_w});
      q_bottom <= $signed({rect_y[C-1], rect_y}) + $signed({2'b00, rect_h});
      q_cx2 <= $signed({rect_x[C-1], rect_x, 1'b0}) + $signed({3'b000, rect_w});
      q_cy2 <= $signed({rect_y[C-1], rect_y, 1'b0}) + $signed({3'b000, rect_h});
    end
  end

  // stage a: overlap extents, strict hit and center offsets
  logic signed [C-1:0] a_rx, a_ry;
  logic [C-2:0]        a_rw, a_rh;
  logic signed [C:0]   a_rx1, a_ry1, a_rr, a_rb, a_minx, a_maxx, a_miny, a_maxy;
  logic signed [C+1:0] a_owr, a_ohr, a_c2x, a_c2y;
  logic signed [C+2:0] a_dx, a_dy;
  logic                a_hit, a_qual;
  logic [DXW-1:0]      a_adx, a_ady;

  always_comb begin
    {a_rx, a_ry, a_rw, a_rh} = rd_data;
    a_rx1 = {a_rx[C-1], a_rx};
    a_ry1 = {a_ry[C-1], a_ry};
    a_rr = a_rx1 + $signed({2'b00, a_rw});
    a_rb = a_ry1 + $signed({2'b00, a_rh});
    a_hit = (q_right > a_rx1) && (q_x < a_rr) && (q_bottom > a_ry1) && (q_y < a_rb);
    a_minx = (q_right < a_rr) ? q_right : a_rr;
    a_maxx = (q_x > a_rx1) ? q_x : a_rx1;
    a_miny = (q_bottom < a_rb) ? q_bottom : a_rb;
    a_maxy = (q_y > a_ry1) ? q_y : a_ry1;
    a_owr = {a_minx[C], a_minx} - {a_maxx[C], a_maxx};
    a_ohr = {a_miny[C], a_miny} - {a_maxy[C], a_maxy};
    a_qual = (a_owr > 0) && (a_ohr > 0);
    a_c2x = $signed({a_rx[C-1], a_rx, 1'b0}) + $signed({3'b000, a_rw});
    a_c2y = $signed({a_ry[C-1], a_ry, 1'b0}) + $signed({3'b000, a_rh});
    a_dx = {a_c2x[C+1], a_c2x} - {q_cx2[C+1], q_cx2};
    a_dy = {a_c2y[C+1], a_c2y} - {q_cy2[C+1], q_cy2};
    a_adx = a_dx[C+2] ? DXW'(-a_dx) : a_dx[DXW-1:0];
    a_ady = a_dy[C+2] ? DXW'(-a_dy) : a_dy[DXW-1:0];
  end

  logic [AW-1:0]  b_idx;
  logic           b_hit, b_qual;
  logic [C-2:0]   b_ow, b_oh, b_rw, b_rh;
  logic [DXW-1:0] b_dx, b_dy;

  always_ff @(posedge clk) begin
    b_idx <= rd_tag;
    b_hit <= a_hit;
    b_qual <= a_qual;
    b_ow <= a_owr[C-2:0];
    b_oh <= a_ohr[C-2:0];
    b_rw <= a_rw;
    b_rh <= a_rh;
    b_dx <= a_adx;
    b_dy <= a_ady;
  end

  // stage b: overlap area, section area and squared offsets
  logic [AW-1:0]    c_idx;
  logic             c_hit, c_qual;
  logic [OVW-1:0]   c_ov, c_area;
  logic [2*DXW-1:0] c_dx2, c_dy2;

  always_ff @(posedge clk) begin
    c_idx <= b_idx;
    c_hit <= b_hit;
    c_qual <= b_qual;
    c_ov <= {{(C-1){1'b0}}, b_ow} * {{(C-1){1'b0}}, b_oh};
    c_area <= {{(C-1){1'b0}}, b_rw} * {{(C-1){1'b0}}, b_rh};
    c_dx2 <= {{DXW{1'b0}}, b_dx} * {{DXW{1'b0}}, b_dx};
    c_dy2 <= {{DXW{1'b0}}, b_dy} * {{DXW{1'b0}}, b_dy};
  end

  // stage c: four times the squared center distance
  logic [AW-1:0]  d_idx;
  logic           d_hit, d_qual;
  logic [OVW-1:0] d_ov, d_area;
  logic [DW-1:0]  d_dist;

  always_ff @(posedge clk) begin
    d_idx <= c_idx;
    d_hit <= c_hit;
    d_qual <= c_qual;
    d_ov <= c_ov;
    d_area <= c_area;
    d_dist <= {1'b0, c_dx2} + {1'b0, c_dy2};
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
      b_valid <= rd_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
  end

  // stage d: ranking against the best so far
  logic           found;
  logic [AW-1:0]  best_idx;
  logic [OVW-1:0] best_area, best_ov;
  logic [DW-1:0]  best_d;
  logic           better, area_eq;

  always_comb begin
    area_eq = d_area == best_area;
    if (select_mode == rbfs_pkg::MODE_FIRST_HIT) begin
      better = d_hit && !found;
    end else begin
      better = d_qual && (!found || (d_area < best_area)
               || (area_eq && (d_ov > best_ov))
               || (area_eq && (d_ov == best_ov) && (d_dist < best_d)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (accept_query) begin
      found <= 1'b0;
    end else if (d_valid && better) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (d_valid && better) begin
      best_idx <= d_idx;
      best_area <= d_area;
      best_ov <= d_ov;
      best_d <= d_dist;
    end
  end

  // result word
  logic [31:0] best_ext;
  assign best_ext = 32'(best_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (accept_query && boss_hit) || finish;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_query && boss_hit) begin
      source <= rbfs_pkg::SRC_BOSS;
      section_index <= '0;
    end else if (finish) begin
      source <= found ? rbfs_pkg::SRC_MATCH : rbfs_pkg::SRC_DEFAULT;
      section_index <= found ? best_ext[rbfs_pkg::INDEX_W-1:0] : '0;
    end
  end

  // assertions
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == rbfs_pkg::ST_IDLE) |-> (!rd_valid && !b_valid && !c_valid && !d_valid))
    else $error("pipeline holds data while idle");

  a_finish_result: assert property (@(posedge clk) disable iff (rst)
    finish |=> (done && (state == rbfs_pkg::ST_IDLE)))
    else $error("scan end without result");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (source != rbfs_pkg::SRC_MATCH)) |-> (section_index == '0))
    else $error("section index set for non-matched result");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    issue |-> (32'(rd_cnt) < MAX_SECTIONS))
    else $error("read beyond table");

  a_no_word_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state == rbfs_pkg::ST_SCAN) |-> !accept)
    else $error("word accepted during scan");

endmodule
